// File: sv/aabe_pkg.sv
package aabe_pkg;

  typedef enum logic [2:0] {
    CMD_ADC     = 3'd0,
    CMD_AND     = 3'd1,
    CMD_ASL_ACC = 3'd2,
    CMD_ASL_MEM = 3'd3,
    CMD_BCC     = 3'd4,
    CMD_BCS     = 3'd5,
    CMD_BEQ     = 3'd6
  } command_t;

  localparam int FLAG_C_BIT = 0;
  localparam int FLAG_Z_BIT = 1;
  localparam int FLAG_V_BIT = 6;
  localparam int FLAG_N_BIT = 7;

  localparam logic [7:0]  STATUS_RESET  = 8'h04;
  localparam logic [15:0] BRANCH_LENGTH = 16'd2;

  localparam logic [1:0] EXTRA_NONE  = 2'd0;
  localparam logic [1:0] EXTRA_TAKEN = 2'd1;
  localparam logic [1:0] EXTRA_PAGE  = 2'd2;

endpackage

// File: sv/accumulator_alu_and_branch_execute_top.sv
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle when not stalled; the accumulator, flag
// and program counter registers are read and rewritten in the same cycle,
// which sets that rate. No request is taken while out_stall holds a result.
// Reset (rst, synchronous): accumulator 0, flags 8'h04, start address and
// program counter 0, no result pending.
module accumulator_alu_and_branch_execute_top
  import aabe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  operand_value,
  input  logic [15:0] target_address,
  input  logic [1:0]  instruction_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  accumulator_out,
  output logic [7:0]  status_out,
  output logic [15:0] pc_out,
  output logic        write_enable,
  output logic [15:0] write_address,
  output logic [7:0]  write_value,
  output logic [1:0]  branch_cycles
);

  logic [15:0] start_address;
  logic [7:0]  accumulator;
  logic [7:0]  status_flags;
  logic [15:0] program_counter;

  logic [7:0]  accumulator_next;
  logic [7:0]  status_next;
  logic [15:0] pc_next;
  logic        write_enable_next;
  logic [15:0] write_address_next;
  logic [7:0]  write_value_next;
  logic [1:0]  extra_next;

  logic        accept;
  logic [8:0]  sum;
  logic [7:0]  shift_src;
  logic [7:0]  shifted;
  logic [15:0] pc_seq;
  logic [15:0] pc_branch;
  logic [15:0] pc_target;
  logic        taken;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign sum       = {1'b0, accumulator} + {1'b0, operand_value}
                   + {8'd0, status_flags[FLAG_C_BIT]};
  assign shift_src = (command_t'(command) == CMD_ASL_ACC) ? accumulator : operand_value;
  assign shifted   = {shift_src[6:0], 1'b0};
  assign pc_seq    = program_counter + {14'd0, instruction_length};
  assign pc_branch = program_counter + BRANCH_LENGTH;
  assign pc_target = pc_branch + {{8{operand_value[7]}}, operand_value};

  always_comb begin
    accumulator_next   = accumulator;
    status_next        = status_flags;
    pc_next            = pc_seq;
    write_enable_next  = 1'b0;
    write_address_next = 16'd0;
    write_value_next   = 8'd0;
    extra_next         = EXTRA_NONE;
    taken              = 1'b0;
    case (command_t'(command))
      CMD_ADC: begin
        accumulator_next        = sum[7:0];
        status_next[FLAG_C_BIT] = sum[8];
        status_next[FLAG_Z_BIT] = (sum[7:0] == 8'd0);
        status_next[FLAG_N_BIT] = sum[7];
        status_next[FLAG_V_BIT] = ~(accumulator[7] ^ operand_value[7])
                                & (accumulator[7] ^ sum[7]);
      end
      CMD_AND: begin
        accumulator_next        = accumulator & operand_value;
        status_next[FLAG_Z_BIT] = ((accumulator & operand_value) == 8'd0);
        status_next[FLAG_N_BIT] = accumulator[7] & operand_value[7];
      end
      CMD_ASL_ACC, CMD_ASL_MEM: begin
        status_next[FLAG_C_BIT] = shift_src[7];
        status_next[FLAG_Z_BIT] = (shifted == 8'd0);
        status_next[FLAG_N_BIT] = shifted[7];
        if (command_t'(command) == CMD_ASL_ACC) begin
          accumulator_next = shifted;
        end else begin
          write_enable_next  = 1'b1;
          write_address_next = target_address;
          write_value_next   = shifted;
        end
      end
      CMD_BCC, CMD_BCS, CMD_BEQ: begin
        if (command_t'(command) == CMD_BCC) begin
          taken = !status_flags[FLAG_C_BIT];
        end else if (command_t'(command) == CMD_BCS) begin
          taken = status_flags[FLAG_C_BIT];
        end else begin
          taken = status_flags[FLAG_Z_BIT];
        end
        pc_next = pc_branch;
        if (taken) begin
          pc_next    = pc_target;
          extra_next = (pc_target[15:8] != pc_branch[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
        end
      end
      default: begin
        // The unused opcode only advances the program counter.
        pc_next = pc_seq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address   <= 16'd0;
      accumulator     <= 8'd0;
      status_flags    <= STATUS_RESET;
      program_counter <= 16'd0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        accumulator  <= accumulator_next;
        status_flags <= status_next;
      end
      // Loading the start address behaves like taking the reset vector.
      if (cfg_write_enable) begin
        start_address   <= cfg_write_data;
        program_counter <= cfg_write_data;
      end else if (accept) begin
        program_counter <= pc_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      accumulator_out <= accumulator_next;
      status_out      <= status_next;
      pc_out          <= pc_next;
      write_enable    <= write_enable_next;
      write_address   <= write_address_next;
      write_value     <= write_value_next;
      branch_cycles   <= extra_next;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request did not produce a result");

  a_cfg_loads_pc: assert property (@(posedge clk) disable iff (rst)
    cfg_write_enable |=> program_counter == $past(cfg_write_data)
                         && start_address == $past(cfg_write_data))
    else $error("start address write did not load the program counter");

  a_state_matches_result: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_write_enable |=> accumulator == accumulator_out
                                    && status_flags == status_out
                                    && program_counter == pc_out)
    else $error("architectural state and result disagree");

  a_write_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> branch_cycles == EXTRA_NONE)
    else $error("memory write reported together with branch cycles");

  a_kept_flags: assert property (@(posedge clk) disable iff (rst)
    status_flags[5:2] == STATUS_RESET[5:2])
    else $error("unaffected status bits changed");

endmodule
